// ===== design/block_energy_noise_gate_macros.svh =====
// ---------------------------------------------------------------------------
// block energy noise gate assertion macros
// shared property shapes for the port-level checker
// ---------------------------------------------------------------------------
`ifndef BLOCK_ENERGY_NOISE_GATE_MACROS_SVH
`define BLOCK_ENERGY_NOISE_GATE_MACROS_SVH

// same-cycle implication
`define BENG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("noise gate check failed");

// next-cycle implication
`define BENG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("noise gate check failed");

`endif

// ===== design/beng_pkg.sv =====
// ---------------------------------------------------------------------------
// beng_pkg
// shared types and constants of the block energy noise gate
// ---------------------------------------------------------------------------
package beng_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int MAX_BLOCK_DEF   = 4096;

    // gate is q1.16, 65536 is fully open
    localparam int GATE_W    = 17;
    localparam int GATE_FRAC = 16;
    localparam int THR_W     = 16;
    localparam int TSQ_W     = 2 * THR_W;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [GATE_W-1:0]    GATE_ONE   = GATE_W'(65536);
    localparam logic [GATE_W-1:0]    GATE_FLOOR = GATE_W'(656);
    // 0.996 in q0.16
    localparam logic [GATE_FRAC-1:0] DECAY_Q16  = GATE_FRAC'(65274);

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1114);
    localparam logic [TSQ_W-1:0] TSQ_RESET = TSQ_W'(THR_RESET) * TSQ_W'(THR_RESET);

    localparam logic CMD_DETECT = 1'b0;
    localparam logic CMD_APPLY  = 1'b1;

    typedef enum logic [1:0] {
        K_DETECT,
        K_DETECT_LAST,
        K_APPLY
    } item_kind_t;

    typedef enum logic [1:0] {
        EV_IDLE,
        EV_MUL,
        EV_CMP
    } eval_state_t;

    typedef struct packed {
        logic       valid;
        item_kind_t kind;
    } q_ctrl_t;

endpackage

// ===== design/beng_if.sv =====
// ---------------------------------------------------------------------------
// beng channel interfaces
// request, result and threshold write channels with valid/ready
// ---------------------------------------------------------------------------
interface beng_item_if #(
    parameter int SAMPLE_BITS = beng_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          last_in_block;

    modport source (output valid, cmd, sample_in, last_in_block, input ready);
    modport sink   (input valid, cmd, sample_in, last_in_block, output ready);
endinterface

interface beng_result_if #(
    parameter int SAMPLE_BITS = beng_pkg::SAMPLE_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic signed [SAMPLE_BITS-1:0]   sample_out;
    logic [beng_pkg::GATE_W-1:0]     gate_level;

    modport source (output valid, sample_out, gate_level, input ready);
    modport sink   (input valid, sample_out, gate_level, output ready);
endinterface

interface beng_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [beng_pkg::THR_W-1:0] gate_threshold;

    modport source (output valid, gate_threshold, input ready);
    modport sink   (input valid, gate_threshold, output ready);
endinterface

// ===== design/block_energy_noise_gate.sv =====
// ---------------------------------------------------------------------------
// block_energy_noise_gate
// a request is queued, multiplied into the issue register, then registered as
//   a result; the detect request that ends a block adds scale and compare steps
// throughput: one request per cycle without back-pressure; after a block end the
//   execute side stops issuing while the gate update settles
// reset: rst_n clears energy, count, gate (closed) and queues at once
// ---------------------------------------------------------------------------
module block_energy_noise_gate #(
    parameter int SAMPLE_BITS = beng_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_BLOCK   = beng_pkg::MAX_BLOCK_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    beng_item_if.sink     item,
    beng_result_if.source result,
    beng_cfg_if.sink      cfg
);
    import beng_pkg::*;

    logic [THR_W-1:0]              thr_reg, thr_next;
    logic [TSQ_W-1:0]              tsq_reg, tsq_next;
    q_ctrl_t                       q_ctrl;
    logic signed [SAMPLE_BITS-1:0] q_sample;
    logic                          q_pop;

    assign cfg.ready = 1'b1;
    assign thr_next  = (cfg.valid && cfg.ready) ? cfg.gate_threshold : thr_reg;
    // squared threshold kept registered for the block compare
    assign tsq_next  = TSQ_W'(thr_reg) * TSQ_W'(thr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            tsq_reg <= TSQ_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
            tsq_reg <= tsq_next;
        end
    end

    beng_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .q_ctrl   (q_ctrl),
        .q_sample (q_sample),
        .q_pop    (q_pop)
    );

    beng_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_BLOCK   (MAX_BLOCK)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_ctrl   (q_ctrl),
        .q_sample (q_sample),
        .q_pop    (q_pop),
        .tsq      (tsq_reg),
        .result   (result)
    );

endmodule

// ===== design/beng_front.sv =====
// ---------------------------------------------------------------------------
// beng_front
// takes requests, classifies them and holds them in a short queue
// ---------------------------------------------------------------------------
module beng_front #(
    parameter int SAMPLE_BITS = beng_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    beng_item_if.sink                     item,
    output beng_pkg::q_ctrl_t             q_ctrl,
    output logic signed [SAMPLE_BITS-1:0] q_sample,
    input  logic                          q_pop
);
    import beng_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    item_kind_t                    kind_mem [QUEUE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] samp_mem [QUEUE_DEPTH];

    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              push;
    item_kind_t        kind;

    always_comb
    begin
        unique case (item.cmd)
            CMD_APPLY:  kind = K_APPLY;
            CMD_DETECT: kind = item.last_in_block ? K_DETECT_LAST : K_DETECT;
        endcase
    end

    assign item.ready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign push       = item.valid && item.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        fill_next = fill_reg + FILL_W'(push) - FILL_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            kind_mem[wr_ptr_reg] <= kind;
            samp_mem[wr_ptr_reg] <= item.sample_in;
        end
    end

    assign q_ctrl.valid = (fill_reg != '0);
    assign q_ctrl.kind  = kind_mem[rd_ptr_reg];
    assign q_sample     = samp_mem[rd_ptr_reg];

endmodule

// ===== design/beng_back.sv =====
// ---------------------------------------------------------------------------
// beng_back
// squares or scales samples, keeps block energy, updates the gate per block
// ---------------------------------------------------------------------------
module beng_back #(
    parameter int SAMPLE_BITS = beng_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_BLOCK   = beng_pkg::MAX_BLOCK_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  beng_pkg::q_ctrl_t             q_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] q_sample,
    output logic                          q_pop,
    input  logic [beng_pkg::TSQ_W-1:0]    tsq,
    beng_result_if.source                 result
);
    import beng_pkg::*;

    localparam int CNT_W       = $clog2(MAX_BLOCK + 1);
    localparam int SQ_W        = 2 * SAMPLE_BITS - 1;
    localparam int ENERGY_FULL = 2 * SAMPLE_BITS - 2 + CNT_W;
    localparam int ENERGY_W    = (ENERGY_FULL > 64) ? 64 : ENERGY_FULL;
    localparam int B_W         = (SAMPLE_BITS > GATE_W + 1) ? SAMPLE_BITS : GATE_W + 1;
    localparam int P_W         = SAMPLE_BITS + B_W;
    // 100*sum*2^32 against count*thr^2*2^(2*(bits-1)), common power removed
    localparam int SH_TOT      = 2 * SAMPLE_BITS - 2;
    localparam int SH_COM      = (SH_TOT > 32) ? 32 : SH_TOT;
    localparam int LSH         = 32 - SH_COM;
    localparam int RSH         = SH_TOT - SH_COM;
    localparam int L_W         = ENERGY_W + 7 + LSH;
    localparam int MUL_W       = CNT_W + TSQ_W;
    localparam int R_W         = MUL_W + RSH;
    localparam int CMP_W       = (L_W > R_W) ? L_W : R_W;
    localparam int DEC_W       = GATE_W + GATE_FRAC;

    // issue stage
    logic                   s1_valid_reg, s1_valid_next;
    item_kind_t             s1_kind_reg;
    logic signed [P_W-1:0]  s1_prod_reg;
    logic signed [B_W-1:0]  op_b;
    logic signed [P_W-1:0]  prod_next;
    logic                   issue;
    logic                   s1_go;
    logic                   out_free;

    // block energy
    logic [ENERGY_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [SQ_W-1:0]        sq;
    logic [ENERGY_W:0]      sum_add;
    logic [ENERGY_W-1:0]    sum_upd;
    logic [CNT_W-1:0]       cnt_upd;
    logic                   can_add;

    // block evaluation
    eval_state_t            ev_state_reg, ev_state_next;
    logic                   ev_start, ev_calc, ev_done;
    logic [ENERGY_W-1:0]    ev_sum_reg;
    logic [CNT_W-1:0]       ev_cnt_reg;
    logic [CMP_W-1:0]       lhs_reg, rhs_reg;
    logic [GATE_W-1:0]      dec_reg;
    logic [CMP_W-1:0]       sum_ext;
    logic [MUL_W-1:0]       cnt_tsq;
    logic [DEC_W-1:0]       dec_full;
    logic [GATE_W-1:0]      gate_reg, gate_next, gate_upd;

    // result register
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;
    logic [GATE_W-1:0]             gate_out_reg;
    logic                          out_from_s1;

    assign out_free = !out_valid_reg || result.ready;
    assign s1_go    = s1_valid_reg && ((s1_kind_reg == K_DETECT_LAST) || out_free);

    // hold issue while a block end is in flight so the gate is settled
    assign issue = q_ctrl.valid && (ev_state_reg == EV_IDLE)
                   && !(s1_valid_reg && (s1_kind_reg == K_DETECT_LAST))
                   && (!s1_valid_reg || s1_go);
    assign q_pop = issue;

    // one signed multiplier: square for detect, sample times gate for apply
    assign op_b      = (q_ctrl.kind == K_APPLY) ? $signed(B_W'(gate_reg)) : B_W'(q_sample);
    assign prod_next = q_sample * op_b;

    assign s1_valid_next = issue ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_kind_reg <= q_ctrl.kind;
            s1_prod_reg <= prod_next;
        end
    end

    // energy accumulation, saturating, stops counting at the block limit
    assign sq      = s1_prod_reg[SQ_W-1:0];
    assign can_add = (cnt_reg < CNT_W'(MAX_BLOCK));
    assign sum_add = {1'b0, sum_reg} + (ENERGY_W + 1)'(sq);
    assign sum_upd = !can_add ? sum_reg : (sum_add[ENERGY_W] ? '1 : sum_add[ENERGY_W-1:0]);
    assign cnt_upd = can_add ? CNT_W'(cnt_reg + 1'b1) : cnt_reg;

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (s1_go && (s1_kind_reg == K_DETECT))
        begin
            sum_next = sum_upd;
            cnt_next = cnt_upd;
        end
        else if (ev_start)
        begin
            sum_next = '0;
            cnt_next = '0;
        end
    end

    // evaluation sequencer: next state
    always_comb
    begin
        unique case (ev_state_reg)
            EV_IDLE: ev_state_next = (s1_go && (s1_kind_reg == K_DETECT_LAST)) ? EV_MUL : EV_IDLE;
            EV_MUL:  ev_state_next = EV_CMP;
            EV_CMP:  ev_state_next = out_free ? EV_IDLE : EV_CMP;
            default: ev_state_next = EV_IDLE;
        endcase
    end

    // evaluation sequencer: outputs
    always_comb
    begin
        ev_start = 1'b0;
        ev_calc  = 1'b0;
        ev_done  = 1'b0;
        unique case (ev_state_reg)
            EV_IDLE: ev_start = s1_go && (s1_kind_reg == K_DETECT_LAST);
            EV_MUL:  ev_calc  = 1'b1;
            EV_CMP:  ev_done  = out_free;
            default: ev_done  = 1'b0;
        endcase
    end

    // times 100 as shift-add
    assign sum_ext  = CMP_W'(ev_sum_reg);
    assign cnt_tsq  = ev_cnt_reg * tsq;
    assign dec_full = gate_reg * DECAY_Q16;

    always_ff @(posedge clk)
    begin
        if (ev_start)
        begin
            ev_sum_reg <= sum_upd;
            ev_cnt_reg <= cnt_upd;
        end
        if (ev_calc)
        begin
            lhs_reg <= ((sum_ext << 6) + (sum_ext << 5) + (sum_ext << 2)) << LSH;
            rhs_reg <= CMP_W'(cnt_tsq) << RSH;
            dec_reg <= dec_full[GATE_FRAC +: GATE_W];
        end
    end

    always_comb
    begin
        priority if (lhs_reg > rhs_reg)
            gate_upd = GATE_ONE;
        else if (gate_reg >= GATE_FLOOR)
            gate_upd = dec_reg;
        else
            gate_upd = gate_reg;
    end

    assign gate_next = ev_done ? gate_upd : gate_reg;

    // result register
    assign out_from_s1    = s1_go && (s1_kind_reg != K_DETECT_LAST);
    assign out_valid_next = (out_from_s1 || ev_done) ? 1'b1
                          : (result.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk)
    begin
        if (out_from_s1)
        begin
            sample_out_reg <= (s1_kind_reg == K_APPLY) ? s1_prod_reg[GATE_FRAC +: SAMPLE_BITS]
                                                       : '0;
            gate_out_reg   <= gate_reg;
        end
        else if (ev_done)
        begin
            sample_out_reg <= '0;
            gate_out_reg   <= gate_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            ev_state_reg  <= EV_IDLE;
            gate_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            ev_state_reg  <= ev_state_next;
            gate_reg      <= gate_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.sample_out = sample_out_reg;
    assign result.gate_level = gate_out_reg;

endmodule

// ===== design/beng_checker.sv =====
// ---------------------------------------------------------------------------
// beng_checker
// port-level checks on the result channel of the noise gate
// ---------------------------------------------------------------------------
`include "block_energy_noise_gate_macros.svh"

module beng_checker #(
    parameter int SAMPLE_BITS = beng_pkg::SAMPLE_BITS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic signed [SAMPLE_BITS-1:0] sample_out,
    input logic [beng_pkg::GATE_W-1:0]   gate_level
);
    import beng_pkg::*;

    // a stalled result holds
    `BENG_ASSERT_NEXT(a_result_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(sample_out) && $stable(gate_level))

    // gate never goes past fully open
    `BENG_ASSERT_IMPLY(a_gate_bound, clk, rst_n, res_valid, gate_level <= GATE_ONE)

    // a closed gate passes nothing
    `BENG_ASSERT_IMPLY(a_closed_silent, clk, rst_n, res_valid && (gate_level == '0), sample_out == '0)

endmodule

bind block_energy_noise_gate beng_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_beng_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .sample_out (result.sample_out),
    .gate_level (result.gate_level)
);

// ===== test/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: block energy noise gate testbench
// feeds detect and apply requests with random gaps and back-pressure,
// predicts every result in-line and compares it field by field
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import beng_pkg::*;

    localparam int SB      = SAMPLE_BITS_DEF;
    localparam int MAX_BLK = MAX_BLOCK_DEF;

    localparam logic [GATE_W-1:0] FULL_GAIN  = 17'd65536;
    localparam logic [GATE_W-1:0] GAIN_FLOOR = 17'd656;
    localparam logic [15:0]       DECAY_MUL  = 16'd65274;
    localparam logic [THR_W-1:0]  THR_AFTER_RESET = 16'd1114;

    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 150;
    localparam int STALL_LIMIT   = 4000;

    typedef struct {
        logic                 cmd;
        logic signed [SB-1:0] sample;
        logic                 last;
        int unsigned          gap;
    } gate_req_t;

    typedef struct {
        logic signed [SB-1:0] sample_out;
        logic [GATE_W-1:0]    gate_level;
    } gate_result_t;

    logic clk = 1'b0;
    logic rst_n;

    beng_item_if #(.SAMPLE_BITS(SB))   item_ch ();
    beng_result_if #(.SAMPLE_BITS(SB)) res_ch ();
    beng_cfg_if                        cfg_ch ();

    block_energy_noise_gate #(
        .SAMPLE_BITS (SB),
        .MAX_BLOCK   (MAX_BLK)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // gate state as the block should hold it
    logic [63:0]       energy_acc = '0;
    int unsigned       block_len  = 0;
    logic [GATE_W-1:0] gain_now   = '0;
    logic [THR_W-1:0]  thr_now    = THR_AFTER_RESET;

    gate_req_t    gate_requests[$];
    gate_result_t gated_due[$];
    gate_req_t    on_bus;
    bit           req_loaded = 1'b0;
    int unsigned  send_idle  = 0;
    int unsigned  recv_idle  = 0;
    int unsigned  send_max   = 0;
    int unsigned  recv_max   = 0;
    int unsigned  mismatch_cnt = 0;
    int unsigned  stall_cycles = 0;
    bit           hold_req = 1'b0;
    logic         hold_off = 1'b0;

    function automatic gate_result_t compute_gated(input gate_req_t r);
        gate_result_t      o;
        logic [SB-1:0]     mag;
        logic [127:0]      loud;
        logic [127:0]      quiet_line;
        logic signed [63:0] prod;
        o.sample_out = '0;
        if (r.cmd == CMD_DETECT)
        begin
            if (block_len < MAX_BLK)
            begin
                mag = r.sample[SB-1] ? -r.sample : r.sample;
                energy_acc = energy_acc + 64'(mag) * 64'(mag);
                block_len++;
            end
            if (r.last)
            begin
                // mean square vs (thr/10)^2, cross-multiplied at matched scale
                loud = (128'(energy_acc) * 128'd100) << 32;
                quiet_line = (128'(block_len) * 128'(thr_now) * 128'(thr_now)) << (2 * (SB - 1));
                if (loud > quiet_line)
                    gain_now = FULL_GAIN;
                else if (gain_now >= GAIN_FLOOR)
                    gain_now = GATE_W'((34'(gain_now) * 34'(DECAY_MUL)) >> 16);
                energy_acc = '0;
                block_len  = 0;
            end
        end
        else
        begin
            prod = 64'(r.sample) * $signed(64'(gain_now));
            o.sample_out = SB'(prod >>> 16);
        end
        o.gate_level = gain_now;
        return o;
    endfunction

    // request driver
    always @(posedge clk)
    begin
        logic offer;
        offer = item_ch.valid;
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                gated_due.push_back(compute_gated(on_bus));
                offer = 1'b0;
                req_loaded = 1'b0;
            end
            if (!offer)
            begin
                if (!req_loaded && gate_requests.size() != 0)
                begin
                    on_bus = gate_requests.pop_front();
                    req_loaded = 1'b1;
                    send_idle = on_bus.gap;
                end
                if (req_loaded)
                begin
                    if (send_idle == 0)
                    begin
                        offer = 1'b1;
                        item_ch.cmd           <= on_bus.cmd;
                        item_ch.sample_in     <= on_bus.sample;
                        item_ch.last_in_block <= on_bus.last;
                    end
                    else
                        send_idle--;
                end
            end
        end
        item_ch.valid <= offer;
    end

    // result monitor
    always @(posedge clk)
    begin
        gate_result_t want;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (gated_due.size() == 0)
                begin
                    mismatch_cnt++;
                    $error("result with no request outstanding: sample_out %0d gate_level %0d",
                           res_ch.sample_out, res_ch.gate_level);
                end
                else
                begin
                    want = gated_due.pop_front();
                    if (res_ch.sample_out !== want.sample_out)
                    begin
                        mismatch_cnt++;
                        $error("sample_out: expected %0d, actual %0d",
                               want.sample_out, res_ch.sample_out);
                    end
                    if (res_ch.gate_level !== want.gate_level)
                    begin
                        mismatch_cnt++;
                        $error("gate_level: expected %0d, actual %0d",
                               want.gate_level, res_ch.gate_level);
                    end
                end
                recv_idle = $urandom_range(0, recv_max);
            end
            else if (recv_idle != 0)
                recv_idle--;
            res_ch.ready <= (recv_idle == 0) && !hold_off;
        end
    end

    // long receiver hold-off, so the block backs up and stalls its input
    always
    begin
        wait (hold_req);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
        hold_req = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void push_req(input logic cmd, input logic signed [SB-1:0] s,
                                     input logic last);
        gate_req_t r;
        r.cmd    = cmd;
        r.sample = s;
        r.last   = last;
        r.gap    = $urandom_range(0, send_max);
        gate_requests.push_back(r);
    endfunction

    // random sample within +-2^amp, now and then a rail or zero
    function automatic logic signed [SB-1:0] pick_sample(input int unsigned amp);
        logic signed [SB-1:0] raw;
        raw = SB'($urandom);
        case ($urandom_range(0, 31))
            0: return {1'b0, {(SB-1){1'b1}}};
            1: return {1'b1, {(SB-1){1'b0}}};
            2: return '0;
            3: return '1;
            default: return raw >>> (SB - 1 - amp);
        endcase
    endfunction

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (gate_requests.size() != 0 || req_loaded || gated_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] v);
        wait_quiet();
        @(posedge clk);
        cfg_ch.gate_threshold <= v;
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        thr_now = v;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic push_random(input int unsigned target);
        int unsigned n;
        int unsigned len;
        int unsigned amp;
        int unsigned k;
        n = 0;
        while (n < target)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                // well-formed block, apply requests mixed in
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 100)
                                                  : $urandom_range(1, 32);
                amp = $urandom_range(0, SB - 1);
                for (k = 0; k < len; k++)
                begin
                    push_req(CMD_DETECT, pick_sample(amp), k == len - 1);
                    n++;
                    if ($urandom_range(0, 2) == 0)
                    begin
                        push_req(CMD_APPLY, pick_sample($urandom_range(0, SB - 1)),
                                 1'($urandom_range(0, 1)));
                        n++;
                    end
                end
            end
            else
            begin
                for (k = 0; k < 4; k++)
                begin
                    push_req(1'($urandom_range(0, 1)), pick_sample(SB - 1),
                             1'($urandom_range(0, 1)));
                    n++;
                end
            end
        end
    endtask

    initial
    begin
        int unsigned k;
        rst_n = 1'b0;
        item_ch.valid         = 1'b0;
        item_ch.cmd           = CMD_DETECT;
        item_ch.sample_in     = '0;
        item_ch.last_in_block = 1'b0;
        res_ch.ready          = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.gate_threshold = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, reset threshold: closed gate, open, rails, one decay step
        send_max = 3;
        recv_max = 3;
        push_req(CMD_APPLY, 24'sd8388607, 1'b0);
        push_req(CMD_APPLY, -24'sd8388608, 1'b1);
        push_req(CMD_DETECT, 24'sd0, 1'b1);
        push_req(CMD_DETECT, -24'sd8388608, 1'b0);
        push_req(CMD_DETECT, 24'sd8388607, 1'b1);
        push_req(CMD_APPLY, 24'sd8388607, 1'b0);
        push_req(CMD_APPLY, -24'sd8388608, 1'b0);
        push_req(CMD_APPLY, -24'sd1, 1'b0);
        push_req(CMD_APPLY, 24'sd1, 1'b0);
        push_req(CMD_DETECT, 24'sd0, 1'b1);
        push_req(CMD_APPLY, -24'sd1, 1'b0);
        push_req(CMD_APPLY, 24'sd1, 1'b0);
        push_req(CMD_APPLY, 24'sh555555, 1'b0);
        push_req(CMD_APPLY, 24'shAAAAAA, 1'b1);

        // threshold 10: sample 128 sits exactly on the line and must not open
        write_threshold(16'd10);
        push_req(CMD_DETECT, 24'sd128, 1'b1);
        push_req(CMD_DETECT, 24'sd129, 1'b1);
        push_req(CMD_DETECT, -24'sd128, 1'b1);

        write_threshold(16'd0);
        push_req(CMD_DETECT, 24'sd1, 1'b1);
        push_req(CMD_DETECT, 24'sd0, 1'b1);

        write_threshold(16'hFFFF);
        push_req(CMD_DETECT, 24'sd8388607, 1'b0);
        push_req(CMD_DETECT, 24'sd0, 1'b1);
        push_req(CMD_DETECT, 24'sd100000, 1'b1);

        // open, then quiet blocks until the gate drops under the floor and stays
        write_threshold(THR_AFTER_RESET);
        send_max = 0;
        recv_max = 0;
        push_req(CMD_DETECT, 24'sd8388607, 1'b1);
        for (k = 0; k < 1160; k++)
        begin
            push_req(CMD_DETECT, 24'sd0, 1'b1);
            if (k % 40 == 0)
                push_req(CMD_APPLY, pick_sample(SB - 1), 1'b0);
        end

        // random phases
        write_threshold(THR_AFTER_RESET);
        send_max = 19;
        recv_max = 19;
        push_random(15);

        write_threshold(16'hFFFF);
        send_max = 0;
        recv_max = 0;
        push_random(15);

        write_threshold(16'd0);
        send_max = 19;
        recv_max = 0;
        push_random(15);

        write_threshold(16'($urandom));
        send_max = 0;
        recv_max = 19;
        push_random(15);

        write_threshold(16'($urandom_range(0, 4000)));
        send_max = 0;
        recv_max = 5;
        hold_req = 1'b1;
        push_random(15);

        write_threshold(16'($urandom_range(0, 2000)));
        send_max = 19;
        recv_max = 19;
        push_random(15);

        wait_quiet();
        if (mismatch_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
